[hw/rtl/htfd_pkg.sv]
// shared types, status codes and crc helper for the humidity/temperature frame decoder
`default_nettype none
package htfd_pkg;

	localparam int unsigned FRAME_LEN = 6;
	localparam int unsigned CNT_W     = 3;

	localparam logic [CNT_W-1:0] IDX_T_MSB   = 3'd0;
	localparam logic [CNT_W-1:0] IDX_H_MSB   = 3'd3;
	localparam logic [CNT_W-1:0] CNT_LAST    = 3'd5;
	localparam logic [CNT_W-1:0] CNT_FULL    = 3'd6;

	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [7:0] CRC_POLY = 8'h31;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_CRC   = 2'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       end_of_read;
		logic [6:0] sensor_address;
	} rx_req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic signed [11:0] temperature_tenths;
		logic [9:0]        humidity_tenths;
		logic [6:0]        source_address;
	} res_req_t;

	typedef logic [FRAME_LEN-1:0][7:0] frame_t;

	// one byte through the crc register, msb first
	function automatic logic [7:0] crc_byte(input logic [7:0] c_in);
		logic [7:0] c;
		c = c_in;
		for (int b = 0; b < 8; b++) begin
			if (c[7]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/htfd_decode.sv]
// crc check and unit scaling of one complete frame
`default_nettype none
module htfd_decode (
	input  htfd_pkg::frame_t   frame,
	input  logic [7:0]         crc_t_part,
	input  logic [7:0]         crc_h_part,
	input  logic               short_frame,
	input  logic [6:0]         address,
	output htfd_pkg::res_req_t res
);
	import htfd_pkg::*;

	// floor(p / 65535) for p below 2^27: shift estimate plus one correction
	function automatic logic [10:0] div_65535(input logic [26:0] p);
		logic [10:0] q0;
		logic [16:0] r;
		q0 = p[26:16];
		r  = {1'b0, p[15:0]} + {6'd0, q0};
		return q0 + {10'd0, (r >= 17'd65535)};
	endfunction

	logic [15:0] raw_t;
	logic [15:0] raw_h;
	logic [26:0] prod_t;
	logic [26:0] prod_h;
	logic [10:0] q_t;
	logic [10:0] q_h;
	logic        crc_ok;

	assign raw_t  = {frame[0], frame[1]};
	assign raw_h  = {frame[3], frame[4]};
	assign prod_t = {11'd0, raw_t} * 27'd1750;
	assign prod_h = {11'd0, raw_h} * 27'd1000;
	assign q_t    = div_65535(prod_t);
	assign q_h    = div_65535(prod_h);
	assign crc_ok = (crc_byte(crc_t_part ^ frame[1]) == frame[2]) &&
	                (crc_byte(crc_h_part ^ frame[4]) == frame[5]);

	always_comb begin
		res.source_address     = address;
		res.status             = ST_OK;
		res.temperature_tenths = '0;
		res.humidity_tenths    = '0;
		if (short_frame) begin
			res.status = ST_SHORT;
		end else if (!crc_ok) begin
			res.status = ST_CRC;
		end else begin
			res.temperature_tenths = $signed({1'b0, q_t}) - 12'sd450;
			res.humidity_tenths    = q_h[9:0];
		end
	end

endmodule
`default_nettype wire

[hw/rtl/humidity_temp_frame_decoder.sv]
// top level of the humidity/temperature sensor frame decoder
// Takes one byte of a sensor read transfer per request and keeps the first six
// (temperature msb, lsb, crc, humidity msb, lsb, crc); later bytes are dropped.
// The request flagged end_of_read gives one result: short read if fewer than six
// bytes came in, crc failed if either word misses its crc-8 (poly 0x31, init 0xff),
// else temperature and humidity in tenths. A byte request is taken every cycle
// while results flow; after its closing byte a result passes the frame store,
// then crc check and scaling into the output register. The input stalls only
// while a finished frame waits behind a stalled result in the output register.
`default_nettype none
module humidity_temp_frame_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	output logic               rx_stall,
	input  htfd_pkg::rx_req_t  rx,
	output logic               res_valid,
	input  logic               res_stall,
	output htfd_pkg::res_req_t res
);
	import htfd_pkg::*;

	// byte store and running state
	frame_t           frame_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       crc_t_q;     // crc after the temperature msb
	logic [7:0]       crc_h_q;     // crc after the humidity msb

	// frame waiting for the decode stage
	logic             pend_s1;
	logic             short_s1;
	logic [6:0]       addr_s1;

	logic             res_valid_q;
	res_req_t         res_q;
	res_req_t         dec_res;

	logic             rx_take;
	logic             adv;

	// a pending frame moves to the output when the output register is free
	assign adv       = pend_s1 && (!res_valid_q || !res_stall);
	assign rx_stall  = pend_s1 && !adv;
	assign rx_take   = rx_valid && !rx_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// payload only: byte store written while the frame is still filling, frame flags, output register
	always_ff @(posedge clk) begin
		if (rx_take && (count_q < CNT_FULL)) begin
			frame_q[count_q] <= rx.rx_byte;
			if (count_q == IDX_T_MSB) begin
				crc_t_q <= crc_byte(CRC_INIT ^ rx.rx_byte);
			end
			if (count_q == IDX_H_MSB) begin
				crc_h_q <= crc_byte(CRC_INIT ^ rx.rx_byte);
			end
		end
		if (rx_take) begin
			short_s1 <= (count_q < CNT_LAST);
			addr_s1  <= rx.sensor_address;
		end
		if (adv) begin
			res_q <= dec_res;
		end
	end

	// control: byte count, pending frame, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rx_take) begin
				if (rx.end_of_read) begin
					count_q <= '0;
				end else if (count_q < CNT_FULL) begin
					count_q <= count_q + 3'd1;
				end
				pend_s1 <= rx.end_of_read;
			end else if (adv) begin
				pend_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	htfd_decode u_decode (
		.frame       (frame_q),
		.crc_t_part  (crc_t_q),
		.crc_h_part  (crc_h_q),
		.short_frame (short_s1),
		.address     (addr_s1),
		.res         (dec_res)
	);

	// byte count never runs past a full frame
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_FULL)
		else $error("byte count past frame length");

	// closing byte restarts the count
	assert property (@(posedge clk) disable iff (!arst_n)
		rx_take && rx.end_of_read |=> count_q == '0)
		else $error("count not cleared after end of read");

	// input stalls only behind a pending frame
	assert property (@(posedge clk) disable iff (!arst_n) rx_stall |-> pend_s1)
		else $error("input stalled with nothing pending");

	// a moved frame shows up as a valid result
	assert property (@(posedge clk) disable iff (!arst_n) adv |=> res_valid_q)
		else $error("result lost on advance");

	// failed frames carry zero readings
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (res_q.status != ST_OK) |->
		(res_q.temperature_tenths == '0) && (res_q.humidity_tenths == '0))
		else $error("nonzero reading on failed frame");

endmodule
`default_nettype wire

[test/frame_decode_checker.sv]
`timescale 1ns / 1ps
// crc helper and result checker for the humidity/temperature frame decoder bench
package htfd_tb_pkg;

	function automatic logic [7:0] word_crc(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] c;
		c = 8'hFF;
		for (int i = 0; i < 2; i++) begin
			c = c ^ ((i == 0) ? hi : lo);
			for (int b = 0; b < 8; b++) begin
				c = c[7] ? ({c[6:0], 1'b0} ^ 8'h31) : {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

module frame_decode_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rx_valid,
	input  logic               rx_stall,
	input  htfd_pkg::rx_req_t  rx,
	input  logic               res_valid,
	input  logic               res_stall,
	input  htfd_pkg::res_req_t res,
	output int                 errors,
	output int                 pending
);
	import htfd_tb_pkg::*;

	logic [2:0] held_count = '0;
	logic [7:0] frame_copy [6];
	htfd_pkg::res_req_t expected_readings [$];
	int mismatch_count = 0;
	int waiting_count = 0;

	assign errors  = mismatch_count;
	assign pending = waiting_count;

	// judge the held frame the way the sensor protocol defines it
	function automatic htfd_pkg::res_req_t decode_frame(input logic [2:0] count,
			input logic [6:0] addr);
		htfd_pkg::res_req_t r;
		int unsigned raw_t;
		int unsigned raw_h;
		int t;
		r = '0;
		r.source_address = addr;
		if (count < htfd_pkg::FRAME_LEN) begin
			r.status = htfd_pkg::ST_SHORT;
		end else if (word_crc(frame_copy[0], frame_copy[1]) != frame_copy[2] ||
				word_crc(frame_copy[3], frame_copy[4]) != frame_copy[5]) begin
			r.status = htfd_pkg::ST_CRC;
		end else begin
			raw_t = 32'({frame_copy[0], frame_copy[1]});
			raw_h = 32'({frame_copy[3], frame_copy[4]});
			t = -450 + int'((raw_t * 1750) / 65535);
			r.status = htfd_pkg::ST_OK;
			r.temperature_tenths = t[11:0];
			r.humidity_tenths = 10'((raw_h * 1000) / 65535);
		end
		return r;
	endfunction

	task automatic report(input string what, input int want, input int got);
		mismatch_count++;
		$display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		htfd_pkg::res_req_t want;
		if (!arst_n) begin
			held_count = '0;
			expected_readings.delete();
			waiting_count = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (expected_readings.size() == 0) begin
					report("unexpected result, status", -1, int'(res.status));
				end else begin
					want = expected_readings.pop_front();
					if (res.status != want.status)
						report("status", int'(want.status), int'(res.status));
					if (res.temperature_tenths != want.temperature_tenths)
						report("temperature_tenths", int'(want.temperature_tenths),
							int'(res.temperature_tenths));
					if (res.humidity_tenths != want.humidity_tenths)
						report("humidity_tenths", int'(want.humidity_tenths),
							int'(res.humidity_tenths));
					if (res.source_address != want.source_address)
						report("source_address", int'(want.source_address),
							int'(res.source_address));
				end
			end
			if (rx_valid && !rx_stall) begin
				// bytes past the sixth are dropped
				if (held_count < htfd_pkg::FRAME_LEN) begin
					frame_copy[held_count] = rx.rx_byte;
					held_count = held_count + 3'd1;
				end
				if (rx.end_of_read) begin
					expected_readings.push_back(decode_frame(held_count, rx.sensor_address));
					held_count = '0;
				end
			end
			waiting_count = expected_readings.size();
		end
	end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// stimulus, watchdog and verdict for the humidity/temperature frame decoder
module tb;
	import htfd_tb_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 300;
	localparam int PHASE_ITEMS    = 430;
	localparam int DRAIN_CYCLES   = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_valid = 1'b0;
	logic res_stall = 1'b0;
	htfd_pkg::rx_req_t rx = '0;
	logic rx_stall;
	logic res_valid;
	htfd_pkg::res_req_t res;

	int errors;
	int pending;
	int sender_idle_pct = 0;
	int receiver_idle_pct = 0;
	bit hold_req = 1'b0;
	int items_sent = 0;
	int quiet_cycles = 0;

	humidity_temp_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx        (rx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	frame_decode_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_valid  (rx_valid),
		.rx_stall  (rx_stall),
		.rx        (rx),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.errors    (errors),
		.pending   (pending)
	);

	always #4 clk = ~clk;

	// result side: random stall, or one long hold-off when asked
	initial begin : receiver
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				res_stall <= 1'b1;
				hold_left--;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				res_stall <= 1'b1;
			end else begin
				res_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
			end
		end
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: watchdog expired", $time);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic eor, input logic [6:0] addr);
		@(negedge clk);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			rx_valid <= 1'b0;
			@(negedge clk);
		end
		rx_valid <= 1'b1;
		rx <= '{rx_byte: b, end_of_read: eor, sensor_address: addr};
		@(posedge clk);
		while (rx_stall) @(posedge clk);
		items_sent++;
	endtask

	// one transfer: len bytes, the first six a frame with good crc unless corrupted
	task automatic send_frame(input int len, input logic [15:0] t_raw, input logic [15:0] h_raw,
			input bit corrupt, input logic [6:0] addr);
		logic [7:0] frame [6];
		logic [7:0] b;
		int pos;
		frame[0] = t_raw[15:8];
		frame[1] = t_raw[7:0];
		frame[2] = word_crc(t_raw[15:8], t_raw[7:0]);
		frame[3] = h_raw[15:8];
		frame[4] = h_raw[7:0];
		frame[5] = word_crc(h_raw[15:8], h_raw[7:0]);
		if (corrupt) begin
			pos = $urandom_range(0, 5);
			frame[pos] ^= 8'($urandom_range(1, 255));
		end
		for (int k = 0; k < len; k++) begin
			b = (k < 6) ? frame[k] : 8'($urandom);
			// only the closing byte carries the address that must come back
			send_byte(b, k == len - 1, (k == len - 1) ? addr : 7'($urandom));
		end
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_transfer();
		int sel;
		int n;
		logic [6:0] addr;
		sel = $urandom_range(0, 99);
		addr = 7'($urandom_range(0, 127));
		if (sel < 60) begin
			send_frame(6, pick_raw(), pick_raw(), 1'b0, addr);
		end else if (sel < 72) begin
			send_frame($urandom_range(7, 10), pick_raw(), pick_raw(), 1'b0, addr);
		end else if (sel < 84) begin
			send_frame($urandom_range(6, 8), pick_raw(), pick_raw(), 1'b1, addr);
		end else if (sel < 94) begin
			send_frame($urandom_range(1, 5), pick_raw(), pick_raw(), 1'b0, addr);
		end else begin
			// noise: bytes with no frame structure
			n = $urandom_range(1, 8);
			for (int k = 0; k < n; k++)
				send_byte(8'($urandom), k == n - 1, 7'($urandom));
		end
	endtask

	initial begin : stimulus
		int target;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		// directed: range extremes, short read, crc failure, extra bytes
		send_frame(6, 16'h0000, 16'h0000, 1'b0, 7'd0);
		send_frame(6, 16'hFFFF, 16'hFFFF, 1'b0, 7'd127);
		send_frame(1, 16'h1234, 16'h5678, 1'b0, 7'h55);
		send_frame(6, 16'h6666, 16'h8000, 1'b1, 7'h2A);
		send_frame(7, 16'h8000, 16'h7FFF, 1'b0, 7'h01);

		target = items_sent;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 25;
					receiver_idle_pct = 76;
				end
				1: begin
					sender_idle_pct = 76;
					receiver_idle_pct = 25;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
					// long result hold-off so the frames back up into the input
					hold_req = 1'b1;
				end
			endcase
			target += PHASE_ITEMS;
			while (items_sent < target) send_random_transfer();
		end

		@(negedge clk);
		rx_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

[humidity_temp_frame_decoder.f]
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_decode.sv
hw/rtl/humidity_temp_frame_decoder.sv
test/frame_decode_checker.sv
test/tb.sv
